@@ rtl/core/scds_pkg.sv @@
// ----------------------------------------------------------------------------
// scds_pkg
// Shared types and constants for the degree sine/cosine series pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package scds_pkg;

	// number of series terms, including the leading term
	localparam int TERMS_DEF = 12;

	// full turn in Q16.16 degrees
	localparam logic [24:0] FULL_TURN = 25'd23592960;
	localparam logic [24:0] DEG90     = 25'd5898240;
	localparam logic [24:0] DEG180    = 25'd11796480;
	localparam logic [24:0] DEG270    = 25'd17694720;

	// round(pi/180 * 2^44)
	localparam logic [38:0] RAD_PER_DEG = 39'd307041569098;

	localparam logic [31:0] Q30_ONE = 32'h4000_0000;

	localparam logic OP_SIN = 1'b0;
	localparam logic OP_COS = 1'b1;

	// one item in flight through the series stages
	typedef struct packed {
		logic               vld;
		logic               cos;
		logic               neg;
		logic [31:0]        r2;
		logic [31:0]        t;
		logic signed [33:0] sum;
	} scds_term_t;

	// folded angle leaving the reduction stages
	typedef struct packed {
		logic        vld;
		logic        cos;
		logic        neg;
		logic [22:0] f;
	} scds_fold_t;

endpackage

`default_nettype wire

@@ rtl/core/scds_reduce.sv @@
// ----------------------------------------------------------------------------
// scds_reduce
// Three stages: modulo 360 by reciprocal multiply, remainder fix, quadrant fold.
// ----------------------------------------------------------------------------
`default_nettype none

module scds_reduce (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  wire                  vld,
	input  wire                  cos,
	input  wire signed [31:0]    angle,
	output scds_pkg::scds_fold_t fold
);

	localparam logic [15:0] RECIP = 16'((64'd1 << 40) / 64'(scds_pkg::FULL_TURN));
	// 2^31 + offset is a multiple of a full turn
	localparam logic [32:0] OFFSET = 33'd23068672;

	logic        vld_s1, cos_s1;
	logic [32:0] x_s1;
	logic [48:0] prod_s1;
	logic        vld_s2, cos_s2;
	logic [24:0] m_s2;

	logic [32:0] x;
	logic [33:0] qft, rem, rem_fix;
	logic [24:0] f;
	logic        neg;

	// offset to unsigned and estimate quotient
	assign x = {1'b0, ~angle[31], angle[30:0]} + OFFSET;

	// remainder with one correction step
	always_comb begin
		qft     = 34'(prod_s1[48:40] * scds_pkg::FULL_TURN);
		rem     = {1'b0, x_s1} - qft;
		rem_fix = (rem >= 34'(scds_pkg::FULL_TURN)) ? rem - 34'(scds_pkg::FULL_TURN) : rem;
	end

	// quadrant fold
	always_comb begin
		f   = m_s2;
		neg = 1'b0;
		if (!cos_s2) begin
			if (m_s2 > scds_pkg::DEG90 && m_s2 < scds_pkg::DEG180) begin
				f = scds_pkg::DEG180 - m_s2;
			end else if (m_s2 >= scds_pkg::DEG180 && m_s2 < scds_pkg::DEG270) begin
				f = m_s2 - scds_pkg::DEG180; neg = 1'b1;
			end else if (m_s2 >= scds_pkg::DEG270) begin
				f = scds_pkg::FULL_TURN - m_s2; neg = 1'b1;
			end
		end else begin
			if (m_s2 > scds_pkg::DEG90 && m_s2 <= scds_pkg::DEG180) begin
				f = scds_pkg::DEG180 - m_s2; neg = 1'b1;
			end else if (m_s2 > scds_pkg::DEG180 && m_s2 <= scds_pkg::DEG270) begin
				f = m_s2 - scds_pkg::DEG180; neg = 1'b1;
			end else if (m_s2 > scds_pkg::DEG270) begin
				f = scds_pkg::FULL_TURN - m_s2;
			end
		end
	end

	// valid bits and folded output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			fold   <= '0;
		end else if (en) begin
			vld_s1   <= vld;
			vld_s2   <= vld_s1;
			fold.vld <= vld_s2;
			fold.cos <= cos_s2;
			fold.neg <= neg;
			fold.f   <= f[22:0];
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			cos_s1    <= cos;
			x_s1      <= x;
			prod_s1   <= x * RECIP;
			cos_s2    <= cos_s1;
			m_s2      <= rem_fix[24:0];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/scds_term.sv @@
// ----------------------------------------------------------------------------
// scds_term
// One series term: multiply by r^2, divide by a stage constant, accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module scds_term #(
	parameter int K = 1
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  scds_pkg::scds_term_t din,
	output scds_pkg::scds_term_t dout
);

	localparam logic [11:0] DS = 12'((2 * K) * (2 * K + 1));
	localparam logic [11:0] DC = 12'((2 * K - 1) * (2 * K));
	localparam logic [33:0] MS = 34'((64'd1 << 34) / 64'(DS));
	localparam logic [33:0] MC = 34'((64'd1 << 34) / 64'(DC));
	localparam logic        ODD = (K % 2) == 1;

	scds_pkg::scds_term_t st_s1, st_s2;
	logic [33:0] u_s1, u_s2;
	logic [67:0] pm_s2;

	logic [11:0] d1, d3;
	logic [63:0] p;
	logic [33:0] q0, q;
	logic [45:0] qd, rem;

	// rounded product scaled back to Q30
	always_comb begin
		d1 = din.cos ? DC : DS;
		p  = 64'(din.t) * 64'(din.r2) + (64'(d1) << 29);
	end

	// quotient estimate correction and accumulation
	always_comb begin
		d3  = st_s2.cos ? DC : DS;
		q0  = pm_s2[67:34];
		qd  = 46'(q0) * 46'(d3);
		rem = {12'd0, u_s2} - qd;
		q   = (rem >= 46'(d3)) ? q0 + 34'd1 : q0;
	end

	// per-stage transaction state with valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1 <= '0;
			st_s2 <= '0;
			dout  <= '0;
		end else if (en) begin
			st_s1     <= din;
			st_s2     <= st_s1;
			dout.vld  <= st_s2.vld;
			dout.cos  <= st_s2.cos;
			dout.neg  <= st_s2.neg;
			dout.r2   <= st_s2.r2;
			dout.t    <= q[31:0];
			dout.sum  <= ODD ? st_s2.sum - $signed({2'b00, q[31:0]})
			                 : st_s2.sum + $signed({2'b00, q[31:0]});
		end
	end

	// division datapath
	always_ff @(posedge clk) begin
		if (en) begin
			u_s1      <= p[63:30];
			u_s2      <= u_s1;
			pm_s2     <= 68'(u_s1) * 68'(st_s1.cos ? MC : MS);
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/sine_cosine_degrees_series_unit.sv @@
// ----------------------------------------------------------------------------
// sine_cosine_degrees_series_unit
// Sine or cosine of a Q16.16 degree angle as a Q2.30 value by Maclaurin series.
// ----------------------------------------------------------------------------
// The unit is a fully pipelined evaluator that takes one transaction every
// clock while not stalled and returns one result per transaction, in order,
// through three reduction stages, two radian stages, three stages per series
// term after the first, and the output register. A stall while a result is
// waiting freezes the whole pipeline.
`default_nettype none

module sine_cosine_degrees_series_unit #(
	parameter int TERMS = scds_pkg::TERMS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire               opcode,
	input  wire signed [31:0] angle_deg,
	output logic              out_valid,
	input  wire               out_stall,
	output logic signed [31:0] value
);

	logic en;
	scds_pkg::scds_fold_t fold;
	scds_pkg::scds_term_t chain [TERMS];
	scds_pkg::scds_term_t seed_r2;

	logic        vld_r1, cos_r1, neg_r1;
	logic [31:0] r_r1;
	logic [61:0] pr;
	logic [63:0] pr2;
	logic signed [33:0] sat, res;

	// global pipeline advance
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	scds_reduce u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld    (in_valid && en),
		.cos    (opcode),
		.angle  (angle_deg),
		.fold   (fold)
	);

	// degrees to radians and square
	assign pr  = 62'(fold.f) * 62'(scds_pkg::RAD_PER_DEG) + 62'(64'd1 << 29);
	assign pr2 = 64'(r_r1) * 64'(r_r1) + (64'd1 << 29);

	// leading term with valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_r1  <= 1'b0;
			seed_r2 <= '0;
		end else if (en) begin
			vld_r1      <= fold.vld;
			seed_r2.vld <= vld_r1;
			seed_r2.cos <= cos_r1;
			seed_r2.neg <= neg_r1;
			seed_r2.r2  <= pr2[61:30];
			seed_r2.t   <= (cos_r1 == scds_pkg::OP_COS) ? scds_pkg::Q30_ONE : r_r1;
			seed_r2.sum <= (cos_r1 == scds_pkg::OP_COS) ? 34'sd1073741824
			                                            : $signed({2'b00, r_r1});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_r1       <= fold.cos;
			neg_r1       <= fold.neg;
			r_r1         <= pr[61:30];
		end
	end

	assign chain[0] = seed_r2;

	// series terms
	for (genvar k = 1; k < TERMS; k++) begin : g_term
		scds_term #(.K(k)) u_term (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.din    (chain[k-1]),
			.dout   (chain[k])
		);
	end

	// saturate and apply quadrant sign
	always_comb begin
		sat = chain[TERMS-1].sum;
		if (sat > 34'sd1073741824)  sat = 34'sd1073741824;
		if (sat < -34'sd1073741824) sat = -34'sd1073741824;
		res = chain[TERMS-1].neg ? -sat : sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= chain[TERMS-1].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value <= res[31:0];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/scds_checker.sv @@
// ----------------------------------------------------------------------------
// scds_checker
// Port-level assertions for the sine/cosine series unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module scds_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               in_stall,
	input wire               out_valid,
	input wire               out_stall,
	input wire signed [31:0] value
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value))
		else $error("stalled result changed");

	// input side stalls exactly when the output is blocked
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output backpressure");

	// result stays within plus or minus one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (value <= 32'sd1073741824 && value >= -32'sd1073741824))
		else $error("result out of range");

	// nothing is valid while reset is asserted
	a_reset: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("valid during reset");

endmodule

bind sine_cosine_degrees_series_unit scds_checker u_scds_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.value     (value)
);

`default_nettype wire
